// ===== design/gestalt_string_similarity_assert.svh =====
// ----------------------------------------------------------------------------
// gestalt string similarity assertion macros
// shared property forms, clocked on clock and quiet during reset
// ----------------------------------------------------------------------------
`ifndef GESTALT_STRING_SIMILARITY_ASSERT_SVH
`define GESTALT_STRING_SIMILARITY_ASSERT_SVH

// same-cycle implication
`define GSS_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GSS_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/gss_pkg.sv =====
// ----------------------------------------------------------------------------
// gss_pkg
// types, sizes and codes of the gestalt string similarity block
// ----------------------------------------------------------------------------
`default_nettype none

package gss_pkg;

   localparam int MAX_LEN   = 64;
   localparam int LEN_W     = $clog2(MAX_LEN + 1);
   localparam int IDX_W     = $clog2(MAX_LEN);
   localparam int ROW_LEN   = MAX_LEN + 1;
   localparam int ROW_DEPTH = 2 * ROW_LEN;
   localparam int ROW_AW    = $clog2(ROW_DEPTH);
   localparam int CHAR_W    = 8;
   localparam int TOT_W     = LEN_W + 1;
   localparam int FRAC_W    = 16;
   localparam int RATIO_W   = 16;
   localparam int DIV_NW    = LEN_W + FRAC_W;
   localparam int DIV_CW    = $clog2(DIV_NW + 1);

   typedef enum logic [1:0] {
      CMD_LOAD_A  = 2'd0,
      CMD_LOAD_B  = 2'd1,
      CMD_COMPUTE = 2'd2
   } gss_cmd_type;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [CHAR_W-1:0] char_value;
   } gss_req_type;

   typedef struct packed {
      logic [LEN_W-1:0]   match_count;
      logic [TOT_W-1:0]   total_length;
      logic [RATIO_W-1:0] ratio_q15;
      logic               overflow_flag;
   } gss_rsp_type;

   // half-open ranges [a0,a1) and [b0,b1)
   typedef struct packed {
      logic [LEN_W-1:0] a0;
      logic [LEN_W-1:0] a1;
      logic [LEN_W-1:0] b0;
      logic [LEN_W-1:0] b1;
   } gss_region_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_POP,
      ST_LOAD,
      ST_ROW,
      ST_BLAT,
      ST_CRD,
      ST_CCALC,
      ST_ANCH,
      ST_PUSHR,
      ST_PUSHL,
      ST_DIV,
      ST_DONE
   } gss_state_type;

endpackage

`default_nettype wire

// ===== design/gss_divider.sv =====
// ----------------------------------------------------------------------------
// gss_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module gss_divider (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [gss_pkg::DIV_NW-1:0] dividend,
   input  wire logic [gss_pkg::TOT_W-1:0]  divisor,
   output logic                            done,
   output logic [gss_pkg::DIV_NW-1:0]      quotient
);

   logic                       busy_ff;
   logic                       done_ff;
   logic [gss_pkg::DIV_CW-1:0] cnt_ff;
   logic [gss_pkg::TOT_W-1:0]  rem_ff;
   logic [gss_pkg::TOT_W-1:0]  dsr_ff;
   logic [gss_pkg::DIV_NW-1:0] quo_ff;
   logic [gss_pkg::TOT_W:0]    rem_sh;
   logic                       fits;

   assign rem_sh = {rem_ff, quo_ff[gss_pkg::DIV_NW-1]};
   assign fits   = (rem_sh >= {1'b0, dsr_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= gss_pkg::DIV_CW'(gss_pkg::DIV_NW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - gss_pkg::DIV_CW'(1);
            if (cnt_ff == gss_pkg::DIV_CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         dsr_ff <= divisor;
         quo_ff <= dividend;
      end else if (busy_ff) begin
         rem_ff <= fits ? gss_pkg::TOT_W'(rem_sh - {1'b0, dsr_ff})
                        : rem_sh[gss_pkg::TOT_W-1:0];
         quo_ff <= {quo_ff[gss_pkg::DIV_NW-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== design/gestalt_string_similarity.sv =====
// ----------------------------------------------------------------------------
// gestalt_string_similarity
// ratcliff-obershelp string similarity over two loaded byte strings
// ----------------------------------------------------------------------------
// Load requests (append a byte to string a or b) are accepted back to back
// while idle, and up to 64 bytes per string are kept; extra bytes are dropped
// and reported in overflow_flag. A compute request runs the gestalt match with
// a region stack in memory: each region scans its longest common substring
// cell by cell, each cell in a read state (string and run-length memory reads)
// and an update state that writes back, with a row-start state and a b-byte
// latch state per row of b, and pop, load and anchor states per region, plus
// the right and left push states when it finds an anchor. The ratio of
// 2*matched/total in q1.15 then comes from a serial divider of 23 steps, whose
// done strobe loads the quotient. A compute with an empty string skips the
// match and goes straight to the result. The block takes no request until the
// compute is finished, and the result waits in an output register while
// loading of the next strings runs.
`default_nettype none

module gestalt_string_similarity (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire gss_pkg::gss_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output gss_pkg::gss_rsp_type      rsp_data
);

   `include "gestalt_string_similarity_assert.svh"

   localparam int LW = gss_pkg::LEN_W;
   localparam int IW = gss_pkg::IDX_W;
   localparam int RW = gss_pkg::ROW_AW;

   gss_pkg::gss_state_type state_ff, state_in;

   // loaded strings
   logic [gss_pkg::CHAR_W-1:0] a_mem [gss_pkg::MAX_LEN];
   logic [gss_pkg::CHAR_W-1:0] b_mem [gss_pkg::MAX_LEN];
   logic [gss_pkg::CHAR_W-1:0] a_rd_ff, b_rd_ff;
   // two rows of diagonal run lengths
   logic [LW-1:0]              row_mem [gss_pkg::ROW_DEPTH];
   logic [LW-1:0]              row_rd_ff;
   // pending regions
   gss_pkg::gss_region_type    stk_mem [gss_pkg::MAX_LEN];
   gss_pkg::gss_region_type    stk_rd_ff;

   logic [LW-1:0]              len_a_ff, len_b_ff;
   logic                       dropped_ff;
   logic [gss_pkg::TOT_W-1:0]  total_ff;
   logic                       ovf_ff;
   logic [LW-1:0]              matched_ff;
   logic [LW-1:0]              depth_ff;
   gss_pkg::gss_region_type    reg_ff;
   logic [LW-1:0]              i_ff, j_ff, best_ff, ea_ff, eb_ff;
   logic [gss_pkg::CHAR_W-1:0] b_char_ff;
   logic                       row_sel_ff;
   logic [gss_pkg::RATIO_W-1:0] ratio_ff;
   logic                       rsp_valid_ff;
   gss_pkg::gss_rsp_type       rsp_data_ff;

   logic                       req_fire;
   logic                       is_compute;
   logic                       empty_str;
   logic                       stk_we;
   gss_pkg::gss_region_type    stk_wdata;
   logic [IW-1:0]              stk_waddr;
   logic                       div_start;
   logic                       div_done;
   logic [gss_pkg::DIV_NW-1:0] div_quo;
   logic                       out_load;

   logic [LW-1:0]              a_sum, b_sum, im1;
   logic [LW-1:0]              reg_la, reg_lb;
   logic [LW-1:0]              run;
   logic                       prev_ok;
   logic [RW-1:0]              row_waddr, row_raddr;
   logic [LW-1:0]              left_la, left_lb;
   logic                       right_ok, left_ok, stk_room;

   assign req_fire   = req_valid && req_ready;
   assign is_compute = (req_data.cmd == gss_pkg::CMD_COMPUTE);
   assign empty_str  = (len_a_ff == '0) || (len_b_ff == '0);

   // region geometry and cell addressing
   assign reg_la = reg_ff.a1 - reg_ff.a0;
   assign reg_lb = reg_ff.b1 - reg_ff.b0;
   assign a_sum  = reg_ff.a0 + i_ff - LW'(1);
   assign b_sum  = reg_ff.b0 + j_ff - LW'(1);
   assign im1    = i_ff - LW'(1);

   assign row_waddr = row_sel_ff ? RW'(i_ff) + RW'(gss_pkg::ROW_LEN) : RW'(i_ff);
   assign row_raddr = row_sel_ff ? RW'(im1) : RW'(im1) + RW'(gss_pkg::ROW_LEN);

   // first row and first column see a zero predecessor
   assign prev_ok = (j_ff != LW'(1)) && (i_ff != LW'(1));
   assign run     = (a_rd_ff == b_char_ff)
                    ? ((prev_ok ? row_rd_ff : LW'(0)) + LW'(1)) : LW'(0);

   // child regions of the anchor
   assign left_la  = ea_ff - best_ff;
   assign left_lb  = eb_ff - best_ff;
   assign right_ok = (ea_ff != reg_la) && (eb_ff != reg_lb);
   assign left_ok  = (left_la != '0) && (left_lb != '0);
   assign stk_room = (depth_ff < LW'(gss_pkg::MAX_LEN));

   // next state and strobes
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      stk_we    = 1'b0;
      stk_waddr = depth_ff[IW-1:0];
      stk_wdata = '0;
      div_start = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         gss_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_fire && is_compute) begin
               if (empty_str) begin
                  state_in = gss_pkg::ST_DONE;
               end else begin
                  // whole strings as the first region
                  stk_we    = 1'b1;
                  stk_waddr = '0;
                  stk_wdata = '{a0: '0, a1: len_a_ff, b0: '0, b1: len_b_ff};
                  state_in  = gss_pkg::ST_POP;
               end
            end
         end
         gss_pkg::ST_POP: begin
            if (depth_ff == '0) begin
               div_start = 1'b1;
               state_in  = gss_pkg::ST_DIV;
            end else begin
               state_in = gss_pkg::ST_LOAD;
            end
         end
         gss_pkg::ST_LOAD:  state_in = gss_pkg::ST_ROW;
         gss_pkg::ST_ROW:   state_in = gss_pkg::ST_BLAT;
         gss_pkg::ST_BLAT:  state_in = gss_pkg::ST_CRD;
         gss_pkg::ST_CRD:   state_in = gss_pkg::ST_CCALC;
         gss_pkg::ST_CCALC: begin
            if (i_ff != reg_la) begin
               state_in = gss_pkg::ST_CRD;
            end else if (j_ff != reg_lb) begin
               state_in = gss_pkg::ST_ROW;
            end else begin
               state_in = gss_pkg::ST_ANCH;
            end
         end
         gss_pkg::ST_ANCH: begin
            state_in = (best_ff == '0) ? gss_pkg::ST_POP : gss_pkg::ST_PUSHR;
         end
         gss_pkg::ST_PUSHR: begin
            stk_we    = right_ok && stk_room;
            stk_wdata = '{a0: reg_ff.a0 + ea_ff, a1: reg_ff.a1,
                          b0: reg_ff.b0 + eb_ff, b1: reg_ff.b1};
            state_in  = gss_pkg::ST_PUSHL;
         end
         gss_pkg::ST_PUSHL: begin
            // left pushed last so it is worked on first
            stk_we    = left_ok && stk_room;
            stk_wdata = '{a0: reg_ff.a0, a1: reg_ff.a0 + left_la,
                          b0: reg_ff.b0, b1: reg_ff.b0 + left_lb};
            state_in  = gss_pkg::ST_POP;
         end
         gss_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = gss_pkg::ST_DONE;
            end
         end
         gss_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               state_in = gss_pkg::ST_IDLE;
            end
         end
         default: state_in = gss_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gss_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         len_a_ff     <= '0;
         len_b_ff     <= '0;
         dropped_ff   <= 1'b0;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            case (req_data.cmd)
               gss_pkg::CMD_LOAD_A: begin
                  if (len_a_ff < LW'(gss_pkg::MAX_LEN)) begin
                     len_a_ff <= len_a_ff + LW'(1);
                  end else begin
                     dropped_ff <= 1'b1;
                  end
               end
               gss_pkg::CMD_LOAD_B: begin
                  if (len_b_ff < LW'(gss_pkg::MAX_LEN)) begin
                     len_b_ff <= len_b_ff + LW'(1);
                  end else begin
                     dropped_ff <= 1'b1;
                  end
               end
               gss_pkg::CMD_COMPUTE: begin
                  len_a_ff   <= '0;
                  len_b_ff   <= '0;
                  dropped_ff <= 1'b0;
               end
               default: ;
            endcase
         end
         if (stk_we) begin
            depth_ff <= depth_ff + LW'(1);
         end else if (state_ff == gss_pkg::ST_POP && depth_ff != '0) begin
            depth_ff <= depth_ff - LW'(1);
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_fire && is_compute) begin
         total_ff   <= gss_pkg::TOT_W'(len_a_ff) + gss_pkg::TOT_W'(len_b_ff);
         ovf_ff     <= dropped_ff;
         matched_ff <= '0;
         ratio_ff   <= '0;
      end
      case (state_ff)
         gss_pkg::ST_LOAD: begin
            reg_ff     <= stk_rd_ff;
            best_ff    <= '0;
            ea_ff      <= '0;
            eb_ff      <= '0;
            j_ff       <= LW'(1);
            row_sel_ff <= 1'b0;
         end
         gss_pkg::ST_ROW:  i_ff <= LW'(1);
         gss_pkg::ST_BLAT: b_char_ff <= b_rd_ff;
         gss_pkg::ST_CCALC: begin
            // strictly longer only, first maximum wins
            if (run > best_ff) begin
               best_ff <= run;
               ea_ff   <= i_ff;
               eb_ff   <= j_ff;
            end
            if (i_ff != reg_la) begin
               i_ff <= i_ff + LW'(1);
            end else begin
               j_ff       <= j_ff + LW'(1);
               row_sel_ff <= !row_sel_ff;
            end
         end
         gss_pkg::ST_ANCH: matched_ff <= matched_ff + best_ff;
         gss_pkg::ST_DIV: begin
            if (div_done) begin
               ratio_ff <= div_quo[gss_pkg::RATIO_W-1:0];
            end
         end
         default: ;
      endcase
      if (out_load) begin
         rsp_data_ff <= '{match_count: matched_ff, total_length: total_ff,
                          ratio_q15: ratio_ff, overflow_flag: ovf_ff};
      end
   end

   // string memories: appended while loading, read during the scan
   always_ff @(posedge clock) begin
      if (req_fire && req_data.cmd == gss_pkg::CMD_LOAD_A
          && len_a_ff < LW'(gss_pkg::MAX_LEN)) begin
         a_mem[len_a_ff[IW-1:0]] <= req_data.char_value;
      end
      a_rd_ff <= a_mem[a_sum[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_data.cmd == gss_pkg::CMD_LOAD_B
          && len_b_ff < LW'(gss_pkg::MAX_LEN)) begin
         b_mem[len_b_ff[IW-1:0]] <= req_data.char_value;
      end
      b_rd_ff <= b_mem[b_sum[IW-1:0]];
   end

   // run lengths: read previous row at i-1, write current row at i
   always_ff @(posedge clock) begin
      if (state_ff == gss_pkg::ST_CCALC) begin
         row_mem[row_waddr] <= run;
      end
      row_rd_ff <= row_mem[row_raddr];
   end

   // region stack, read at the top
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_waddr] <= stk_wdata;
      end
      stk_rd_ff <= stk_mem[IW'(depth_ff - LW'(1))];
   end

   gss_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({matched_ff, gss_pkg::FRAC_W'(0)}),
      .divisor  (total_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `GSS_ASSERT_IMP(a_depth_bound, 1'b1, depth_ff <= LW'(gss_pkg::MAX_LEN),
      "region stack deeper than capacity")
   `GSS_ASSERT_IMP(a_best_bound, state_ff == gss_pkg::ST_CRD,
      best_ff <= reg_la && best_ff <= reg_lb, "anchor longer than region")
   `GSS_ASSERT_NEXT(a_empty_skip, req_fire && is_compute && empty_str,
      state_ff == gss_pkg::ST_DONE, "empty string compute did not skip matching")
   `GSS_ASSERT_IMP(a_pop_nonempty, state_ff == gss_pkg::ST_LOAD,
      stk_rd_ff.a1 > stk_rd_ff.a0 && stk_rd_ff.b1 > stk_rd_ff.b0,
      "popped region has an empty side")

endmodule

`default_nettype wire

// ===== bench/gestalt_string_similarity_test.sv =====
// ----------------------------------------------------------------------------
// gestalt_string_similarity_test
// self-checking bench: directed table then random string pairs, every result
// compared field by field, typed table rows with their given values and the
// rest with an in-bench gestalt match predictor
`timescale 1ns / 100ps

module gestalt_string_similarity_test;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 500;
   localparam int IDLE_LIMIT   = 1000000;
   localparam int DRAIN_CYCLES = 64;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   gss_pkg::gss_req_type req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   gss_pkg::gss_rsp_type rsp_data;

   gestalt_string_similarity dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #2 clock = ~clock;

   // predictor copy of the block's loaded strings
   logic [gss_pkg::CHAR_W-1:0] model_a [gss_pkg::MAX_LEN];
   logic [gss_pkg::CHAR_W-1:0] model_b [gss_pkg::MAX_LEN];
   int                model_len_a = 0;
   int                model_len_b = 0;
   bit                model_dropped = 0;

   gss_pkg::gss_rsp_type expected_rsp_q [$];
   int          fail_count = 0;
   int          idle_cycles = 0;

   // sender burst state
   int burst_left = 0;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
      fail_count++;
   endtask

   // ratcliff-obershelp match count with an explicit region stack
   function automatic int gestalt_match_count();
      int st_a0 [gss_pkg::MAX_LEN];
      int st_a1 [gss_pkg::MAX_LEN];
      int st_b0 [gss_pkg::MAX_LEN];
      int st_b1 [gss_pkg::MAX_LEN];
      int prev_row [gss_pkg::MAX_LEN+1];
      int cur_row [gss_pkg::MAX_LEN+1];
      int depth, total, a0, a1, b0, b1, best, end_a, end_b, i, j, k;
      depth = 0;
      total = 0;
      st_a0[0] = 0; st_a1[0] = model_len_a; st_b0[0] = 0; st_b1[0] = model_len_b;
      depth = 1;
      while (depth > 0) begin
         depth--;
         a0 = st_a0[depth]; a1 = st_a1[depth]; b0 = st_b0[depth]; b1 = st_b1[depth];
         best = 0; end_a = 0; end_b = 0;
         for (k = 0; k <= gss_pkg::MAX_LEN; k++) begin
            prev_row[k] = 0;
            cur_row[k] = 0;
         end
         for (j = 1; j <= b1 - b0; j++) begin
            cur_row[0] = 0;
            for (i = 1; i <= a1 - a0; i++) begin
               if (model_a[a0+i-1] == model_b[b0+j-1]) begin
                  cur_row[i] = prev_row[i-1] + 1;
                  // strictly longer only, so the first maximum stays
                  if (cur_row[i] > best) begin
                     best = cur_row[i]; end_a = i; end_b = j;
                  end
               end else begin
                  cur_row[i] = 0;
               end
            end
            prev_row = cur_row;
         end
         if (best == 0) continue;
         total += best;
         // right suffixes first, then left prefixes, so left pops first
         if (a0 + end_a < a1 && b0 + end_b < b1 && depth < gss_pkg::MAX_LEN) begin
            st_a0[depth] = a0 + end_a; st_a1[depth] = a1;
            st_b0[depth] = b0 + end_b; st_b1[depth] = b1;
            depth++;
         end
         if (end_a - best > 0 && end_b - best > 0 && depth < gss_pkg::MAX_LEN) begin
            st_a0[depth] = a0; st_a1[depth] = a0 + end_a - best;
            st_b0[depth] = b0; st_b1[depth] = b0 + end_b - best;
            depth++;
         end
      end
      return total;
   endfunction

   // advance predictor by one accepted request; returns 1 when a result follows
   function automatic bit predict_similarity(input gss_pkg::gss_req_type req,
                                             output gss_pkg::gss_rsp_type rsp);
      int total, matched, ratio;
      rsp = '0;
      case (req.cmd)
         gss_pkg::CMD_LOAD_A: begin
            if (model_len_a < gss_pkg::MAX_LEN) begin
               model_a[model_len_a] = req.char_value;
               model_len_a++;
            end else begin
               model_dropped = 1;
            end
            return 0;
         end
         gss_pkg::CMD_LOAD_B: begin
            if (model_len_b < gss_pkg::MAX_LEN) begin
               model_b[model_len_b] = req.char_value;
               model_len_b++;
            end else begin
               model_dropped = 1;
            end
            return 0;
         end
         gss_pkg::CMD_COMPUTE: begin
            total = model_len_a + model_len_b;
            if (model_len_a == 0 || model_len_b == 0) begin
               matched = 0;
               ratio = 0;
            end else begin
               matched = gestalt_match_count();
               ratio = (matched * 65536) / total;
            end
            rsp.match_count   = matched[gss_pkg::LEN_W-1:0];
            rsp.total_length  = total[gss_pkg::TOT_W-1:0];
            rsp.ratio_q15     = ratio[gss_pkg::RATIO_W-1:0];
            rsp.overflow_flag = model_dropped;
            model_len_a = 0;
            model_len_b = 0;
            model_dropped = 0;
            return 1;
         end
         default: return 0;
      endcase
   endfunction

   // present one request, hold it until accepted, then idle per burst pattern
   task automatic send_request(input gss_pkg::gss_req_type req, input bit typed,
                               input gss_pkg::gss_rsp_type typed_rsp);
      gss_pkg::gss_rsp_type predicted;
      bit has_rsp;
      req_valid <= 1'b1;
      req_data  <= req;
      do @(posedge clock); while (!req_ready);
      has_rsp = predict_similarity(req, predicted);
      if (has_rsp) expected_rsp_q.push_back(typed ? typed_rsp : predicted);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(30, 80)
                                                : $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // receiver: result check, stall pattern and the watchdog
   int stall_mode = 0;
   always @(posedge clock) begin
      gss_pkg::gss_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp_q.size() == 0) begin
            report_mismatch("unexpected result", 1, 0);
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_data.match_count !== want.match_count)
               report_mismatch("match_count", rsp_data.match_count, want.match_count);
            if (rsp_data.total_length !== want.total_length)
               report_mismatch("total_length", rsp_data.total_length, want.total_length);
            if (rsp_data.ratio_q15 !== want.ratio_q15)
               report_mismatch("ratio_q15", rsp_data.ratio_q15, want.ratio_q15);
            if (rsp_data.overflow_flag !== want.overflow_flag)
               report_mismatch("overflow_flag", rsp_data.overflow_flag,
                               want.overflow_flag);
         end
      end
      // switch between always-ready, light and heavy stalls now and then
      if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= $urandom_range(0, 3) != 0;
         default: rsp_ready <= $urandom_range(0, 3) == 0;
      endcase
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog expired");
         $display("gestalt_string_similarity regression: fail");
         $finish;
      end
   end

   typedef struct {
      logic [1:0]                 cmd;
      logic [gss_pkg::CHAR_W-1:0] char_value;
      bit                         typed;
      gss_pkg::gss_rsp_type       rsp;
   } stim_row_type;

   stim_row_type directed_rows [] = '{
      // compute right after reset: both strings empty
      '{gss_pkg::CMD_COMPUTE, 8'h00, 1, '{7'd0, 8'd0, 16'd0, 1'b0}},
      // identical single bytes, extreme low value
      '{gss_pkg::CMD_LOAD_A,  8'h00, 0, '0},
      '{gss_pkg::CMD_LOAD_B,  8'h00, 0, '0},
      '{gss_pkg::CMD_COMPUTE, 8'hFF, 1, '{7'd1, 8'd2, 16'd32768, 1'b0}},
      // no common byte
      '{gss_pkg::CMD_LOAD_A,  8'hFF, 0, '0},
      '{gss_pkg::CMD_LOAD_B,  8'h55, 0, '0},
      '{gss_pkg::CMD_COMPUTE, 8'h00, 1, '{7'd0, 8'd2, 16'd0, 1'b0}},
      // unused command in between, then compute with b empty
      '{gss_pkg::CMD_LOAD_A,  8'hAA, 0, '0},
      '{CMD_UNUSED,           8'hFF, 0, '0},
      '{gss_pkg::CMD_COMPUTE, 8'h00, 1, '{7'd0, 8'd1, 16'd0, 1'b0}},
      // a empty
      '{gss_pkg::CMD_LOAD_B,  8'h7E, 0, '0},
      '{gss_pkg::CMD_COMPUTE, 8'h00, 1, '{7'd0, 8'd1, 16'd0, 1'b0}},
      // equal-length anchors, first one kept
      '{gss_pkg::CMD_LOAD_A,  8'h61, 0, '0},
      '{gss_pkg::CMD_LOAD_A,  8'h62, 0, '0},
      '{gss_pkg::CMD_LOAD_B,  8'h62, 0, '0},
      '{gss_pkg::CMD_LOAD_B,  8'h61, 0, '0},
      '{gss_pkg::CMD_COMPUTE, 8'h00, 0, '0},
      // anchor at the end of a and the start of b, so no child region survives
      '{gss_pkg::CMD_LOAD_A,  8'h61, 0, '0},
      '{gss_pkg::CMD_LOAD_A,  8'h62, 0, '0},
      '{gss_pkg::CMD_LOAD_A,  8'h61, 0, '0},
      '{gss_pkg::CMD_LOAD_B,  8'h62, 0, '0},
      '{gss_pkg::CMD_LOAD_B,  8'h61, 0, '0},
      '{gss_pkg::CMD_LOAD_B,  8'h62, 0, '0},
      '{CMD_UNUSED,           8'h00, 0, '0},
      '{gss_pkg::CMD_COMPUTE, 8'h00, 0, '0}
   };

   // one string pair of random content, loads interleaved, then compute
   task automatic send_string_pair(output int sent);
      int la, lb, left_a, left_b, pick, alphabet;
      gss_pkg::gss_req_type req;
      pick = $urandom_range(0, 99);
      if (pick < 80)      begin la = $urandom_range(0, 10);  lb = $urandom_range(0, 10);  end
      else if (pick < 96) begin la = $urandom_range(8, 40);  lb = $urandom_range(1, 24);  end
      else                begin la = $urandom_range(60, 68); lb = $urandom_range(60, 68); end
      alphabet = $urandom_range(0, 2);
      left_a = la;
      left_b = lb;
      sent = 0;
      while (left_a + left_b > 0) begin
         if (left_b == 0 || (left_a > 0 && $urandom_range(0, 1))) begin
            req.cmd = gss_pkg::CMD_LOAD_A; left_a--;
         end else begin
            req.cmd = gss_pkg::CMD_LOAD_B; left_b--;
         end
         case (alphabet)
            0:       req.char_value = 8'(8'h61 + $urandom_range(0, 2));
            1:       req.char_value = {$urandom_range(0, 1) ? 4'hF : 4'h0,
                                        4'($urandom_range(0, 3))};
            default: req.char_value = 8'($urandom);
         endcase
         send_request(req, 0, '0);
         sent++;
         // stray unused command, ignored by the block
         if ($urandom_range(0, 39) == 0)
            send_request('{CMD_UNUSED, 8'($urandom)}, 0, '0);
      end
      req.cmd = gss_pkg::CMD_COMPUTE;
      req.char_value = 8'($urandom);
      send_request(req, 0, '0);
      sent++;
   endtask

   initial begin
      int items, sent, k;
      bit paused;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (k = 0; k < directed_rows.size(); k++)
         send_request('{directed_rows[k].cmd, directed_rows[k].char_value},
                      directed_rows[k].typed, directed_rows[k].rsp);

      items = 0;
      paused = 0;
      while (items < RANDOM_ITEMS) begin
         send_string_pair(sent);
         items += sent;
         // hold off once until every pending result has drained
         if (!paused && items > RANDOM_ITEMS / 2) begin
            paused = 1;
            req_valid <= 1'b0;
            @(posedge clock);
            while (expected_rsp_q.size() != 0) @(posedge clock);
         end
      end
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("gestalt_string_similarity regression: pass");
      else
         $display("gestalt_string_similarity regression: fail");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/gss_pkg.sv
design/gss_divider.sv
design/gestalt_string_similarity.sv
bench/gestalt_string_similarity_test.sv
